### hdl/priority_task_queue_tracker_unit_defines.svh
// Assertion macros used by the tracker top level.
`ifndef PRIORITY_TASK_QUEUE_TRACKER_UNIT_DEFINES_SVH
`define PRIORITY_TASK_QUEUE_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition implies consequence in the same cycle.
`define PTQ_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ptq check failed");
// Condition implies consequence in the next cycle.
`define PTQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ptq check failed");
`else
`define PTQ_ASSERT_NOW(lbl, clk, rst_n, a, c)
`define PTQ_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

### hdl/ptq_pkg.sv
`default_nettype none
package ptq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int MAX_RES   = 16;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic [3:0] {
    KIND_SUBMIT   = 4'd0,
    KIND_WAIT     = 4'd1,
    KIND_CANCEL   = 4'd2,
    KIND_STATUS   = 4'd3,
    KIND_DISPATCH = 4'd4,
    KIND_DONE     = 4'd5,
    KIND_PURGE    = 4'd6,
    KIND_RESET    = 4'd7,
    KIND_FLUSH    = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    RK_REPLY  = 2'd0,
    RK_NOTICE = 2'd1,
    RK_GRANT  = 2'd2
  } rkind_t;

  // reported status
  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_ACTIVE   = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_FAILURE  = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  // stored status
  localparam logic [1:0] EST_PENDING  = 2'd0;
  localparam logic [1:0] EST_ACTIVE   = 2'd1;
  localparam logic [1:0] EST_COMPLETE = 2'd2;
  localparam logic [1:0] EST_FAILURE  = 2'd3;

  localparam logic [1:0] GEN_PURGE = 2'd2;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
    logic [1:0]  st;
    logic [1:0]  gen;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  rkind;
    logic [15:0] tag;
    logic [2:0]  st;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef struct packed {
    logic                 vld;
    logic [RES_IDX_W-1:0] idx;
    res_t                 data;
  } push_t;

  typedef struct packed {
    logic                 go;
    logic [RES_CNT_W-1:0] n;
    logic [OUT_CNT_W-1:0] outst;
  } drain_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POST,
    S_FINISH,
    S_WAIT
  } seq_state_t;

  typedef enum logic [2:0] {
    SM_FIND,
    SM_DISP,
    SM_PEND,
    SM_MARK,
    SM_FIN
  } scan_mode_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_REQ,
    D_LOAD,
    D_HOLD
  } drain_state_t;

  function automatic logic is_fin(input logic [1:0] st);
    return (st == EST_COMPLETE) || (st == EST_FAILURE);
  endfunction

endpackage
`default_nettype wire

### hdl/ptq_ram.sv
`default_nettype none
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/ptq_seq.sv
`default_nettype none
module ptq_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [3:0]       in_kind,
  input  wire logic [15:0]      in_task_tag,
  input  wire logic [7:0]       in_priority_req,
  input  wire logic             in_success,
  output ptq_pkg::push_t        push,
  output ptq_pkg::drain_t       drain,
  input  wire logic             drain_done
);

  ptq_pkg::seq_state_t state_r, state_nxt;
  ptq_pkg::scan_mode_t mode_r, mode_nxt;

  logic [3:0]                     kind_r, kind_nxt;
  logic [15:0]                    tag_r, tag_nxt;
  logic [7:0]                     prio_r, prio_nxt;
  logic                           succ_r, succ_nxt;
  logic [ptq_pkg::DEPTH-1:0]      valid_r, valid_nxt;
  logic [ptq_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           gen_r, gen_nxt;
  logic [31:0]                    stamp_r, stamp_nxt;
  logic [ptq_pkg::IDX_W:0]        sidx_r, sidx_nxt;
  logic                           rv_r, rv_nxt;
  logic [ptq_pkg::IDX_W-1:0]      ridx_r, ridx_nxt;
  logic                           found_r, found_nxt;
  logic [ptq_pkg::IDX_W-1:0]      bidx_r, bidx_nxt;
  ptq_pkg::entry_t                bword_r, bword_nxt;
  logic [31:0]                    bage_r, bage_nxt;
  logic                           ffound_r, ffound_nxt;
  logic [ptq_pkg::IDX_W-1:0]      fidx_r, fidx_nxt;
  logic [ptq_pkg::RES_CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic                           we;
  logic [ptq_pkg::IDX_W-1:0]      waddr;
  ptq_pkg::entry_t                wdata;
  ptq_pkg::entry_t                rd;
  logic [ptq_pkg::ENTRY_W-1:0]    rd_raw;

  logic                           v;
  logic [1:0]                     g;
  logic [31:0]                    age;
  logic                           mark;
  logic                           better;
  logic                           room;
  ptq_pkg::entry_t                e;
  logic [1:0]                     new_st;

  ptq_ram #(
    .WIDTH (ptq_pkg::ENTRY_W),
    .DEPTH (ptq_pkg::DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (sidx_r[ptq_pkg::IDX_W-1:0]),
    .rdata (rd_raw)
  );

  assign rd       = ptq_pkg::entry_t'(rd_raw);
  assign in_ready = (state_r == ptq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ptq_pkg::S_IDLE;
      valid_r   <= '0;
      cnt_r     <= '0;
      gen_r     <= 1'b0;
      stamp_r   <= '0;
      rv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      gen_r     <= gen_nxt;
      stamp_r   <= stamp_nxt;
      rv_r      <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    kind_r    <= kind_nxt;
    tag_r     <= tag_nxt;
    prio_r    <= prio_nxt;
    succ_r    <= succ_nxt;
    sidx_r    <= sidx_nxt;
    ridx_r    <= ridx_nxt;
    found_r   <= found_nxt;
    bidx_r    <= bidx_nxt;
    bword_r   <= bword_nxt;
    bage_r    <= bage_nxt;
    ffound_r  <= ffound_nxt;
    fidx_r    <= fidx_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  // per-entry evaluation during a scan
  always_comb begin
    v   = valid_r[ridx_r];
    g   = (kind_r == ptq_pkg::KIND_RESET) ? ptq_pkg::GEN_PURGE : {1'b0, gen_r};
    age = stamp_r - rd.stamp;
    mark = 1'b0;
    case (mode_r)
      ptq_pkg::SM_DISP: mark = v && (rd.st == ptq_pkg::EST_PENDING);
      ptq_pkg::SM_PEND: mark = v && (rd.st == ptq_pkg::EST_PENDING) && (rd.gen != g);
      ptq_pkg::SM_FIN:  mark = v && ptq_pkg::is_fin(rd.st) &&
                               ((kind_r == ptq_pkg::KIND_FLUSH) || (rd.gen != g) ||
                                (rd.gen == ptq_pkg::GEN_PURGE));
      default:          mark = 1'b0;
    endcase
    if (!found_r) begin
      better = 1'b1;
    end else if ((mode_r != ptq_pkg::SM_FIN) && (rd.prio != bword_r.prio)) begin
      better = rd.prio > bword_r.prio;
    end else begin
      better = age > bage_r;
    end
    room = res_cnt_r < ptq_pkg::RES_CNT_W'(ptq_pkg::MAX_RES);
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    kind_nxt    = kind_r;
    tag_nxt     = tag_r;
    prio_nxt    = prio_r;
    succ_nxt    = succ_r;
    valid_nxt   = valid_r;
    cnt_nxt     = cnt_r;
    gen_nxt     = gen_r;
    stamp_nxt   = stamp_r;
    sidx_nxt    = sidx_r;
    rv_nxt      = 1'b0;
    ridx_nxt    = ridx_r;
    found_nxt   = found_r;
    bidx_nxt    = bidx_r;
    bword_nxt   = bword_r;
    bage_nxt    = bage_r;
    ffound_nxt  = ffound_r;
    fidx_nxt    = fidx_r;
    res_cnt_nxt = res_cnt_r;
    we          = 1'b0;
    waddr       = ridx_r;
    wdata       = rd;
    e           = bword_r;
    new_st      = succ_r ? ptq_pkg::EST_COMPLETE : ptq_pkg::EST_FAILURE;
    push        = '0;
    push.idx    = res_cnt_r[ptq_pkg::RES_IDX_W-1:0];
    push.data.tag   = tag_r;
    push.data.rkind = ptq_pkg::RK_REPLY;
    push.data.st    = ptq_pkg::ST_ERROR;
    drain       = '0;

    unique case (state_r)
      ptq_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          tag_nxt     = in_task_tag;
          prio_nxt    = in_priority_req;
          succ_nxt    = in_success;
          res_cnt_nxt = '0;
          found_nxt   = 1'b0;
          ffound_nxt  = 1'b0;
          sidx_nxt    = '0;
          state_nxt   = ptq_pkg::S_SCAN;
          case (in_kind)
            ptq_pkg::KIND_SUBMIT, ptq_pkg::KIND_WAIT, ptq_pkg::KIND_CANCEL,
            ptq_pkg::KIND_STATUS, ptq_pkg::KIND_DONE: mode_nxt = ptq_pkg::SM_FIND;
            ptq_pkg::KIND_DISPATCH:                   mode_nxt = ptq_pkg::SM_DISP;
            ptq_pkg::KIND_PURGE, ptq_pkg::KIND_RESET: mode_nxt = ptq_pkg::SM_PEND;
            ptq_pkg::KIND_FLUSH:                      mode_nxt = ptq_pkg::SM_FIN;
            default: begin
              mode_nxt  = ptq_pkg::SM_FIND;
              state_nxt = ptq_pkg::S_POST;
            end
          endcase
        end
      end

      ptq_pkg::S_SCAN: begin
        if (sidx_r < (ptq_pkg::IDX_W + 1)'(ptq_pkg::DEPTH)) begin
          rv_nxt   = 1'b1;
          ridx_nxt = sidx_r[ptq_pkg::IDX_W-1:0];
          sidx_nxt = sidx_r + 1'b1;
        end
        if (rv_r) begin
          case (mode_r)
            ptq_pkg::SM_FIND: begin
              if (v && (rd.tag == tag_r) && !found_r) begin
                found_nxt = 1'b1;
                bidx_nxt  = ridx_r;
                bword_nxt = rd;
              end
              if (!v && !ffound_r) begin
                ffound_nxt = 1'b1;
                fidx_nxt   = ridx_r;
              end
            end
            ptq_pkg::SM_MARK: begin
              if (v && (rd.st == ptq_pkg::EST_ACTIVE) && (rd.gen != g)) begin
                we        = 1'b1;
                wdata.gen = ptq_pkg::GEN_PURGE;
              end
            end
            default: begin
              if (mark && better) begin
                found_nxt = 1'b1;
                bidx_nxt  = ridx_r;
                bword_nxt = rd;
                bage_nxt  = age;
              end
            end
          endcase
          if (ridx_r == ptq_pkg::IDX_W'(ptq_pkg::DEPTH - 1)) begin
            state_nxt = ptq_pkg::S_POST;
          end
        end
      end

      ptq_pkg::S_POST: begin
        unique case (mode_r)
          ptq_pkg::SM_FIND: begin
            push.vld  = 1'b1;
            state_nxt = ptq_pkg::S_FINISH;
            case (kind_r)
              ptq_pkg::KIND_SUBMIT: begin
                if (!found_r) begin
                  if (ffound_r) begin
                    we          = 1'b1;
                    waddr       = fidx_r;
                    wdata.tag   = tag_r;
                    wdata.prio  = prio_r;
                    wdata.st    = ptq_pkg::EST_PENDING;
                    wdata.gen   = {1'b0, gen_r};
                    wdata.stamp = stamp_r;
                    valid_nxt[fidx_r] = 1'b1;
                    stamp_nxt   = stamp_r + 32'd1;
                    cnt_nxt     = cnt_r + 1'b1;
                    push.data.st = ptq_pkg::ST_PENDING;
                  end
                end else begin
                  push.data.st = {1'b0, bword_r.st};
                  waddr = bidx_r;
                  e.gen = {1'b0, gen_r};
                  if (bword_r.st == ptq_pkg::EST_PENDING) begin
                    if (bword_r.prio != prio_r) begin
                      e.prio    = prio_r;
                      e.stamp   = stamp_r;
                      stamp_nxt = stamp_r + 32'd1;
                    end
                    we    = 1'b1;
                    wdata = e;
                  end else if (bword_r.st == ptq_pkg::EST_ACTIVE) begin
                    we    = 1'b1;
                    wdata = e;
                  end else begin
                    valid_nxt[bidx_r] = 1'b0;
                  end
                end
              end
              ptq_pkg::KIND_WAIT: begin
                if (found_r) begin
                  push.data.st = {1'b0, bword_r.st};
                  if (ptq_pkg::is_fin(bword_r.st)) begin
                    valid_nxt[bidx_r] = 1'b0;
                  end
                end
              end
              ptq_pkg::KIND_CANCEL: begin
                if (found_r) begin
                  push.data.st = {1'b0, bword_r.st};
                  if (bword_r.st != ptq_pkg::EST_ACTIVE) begin
                    valid_nxt[bidx_r] = 1'b0;
                  end
                  if (bword_r.st == ptq_pkg::EST_PENDING) begin
                    cnt_nxt = cnt_r - 1'b1;
                  end
                end
              end
              ptq_pkg::KIND_STATUS: begin
                if (found_r) begin
                  push.data.st = {1'b0, bword_r.st};
                end
              end
              ptq_pkg::KIND_DONE: begin
                if (found_r && (bword_r.st == ptq_pkg::EST_ACTIVE)) begin
                  e.st        = new_st;
                  e.stamp     = stamp_r;
                  we          = 1'b1;
                  waddr       = bidx_r;
                  wdata       = e;
                  stamp_nxt   = stamp_r + 32'd1;
                  cnt_nxt     = cnt_r - 1'b1;
                  push.data.st = {1'b0, new_st};
                end
              end
              default: begin
                push.data.st = ptq_pkg::ST_ERROR;
              end
            endcase
            res_cnt_nxt = res_cnt_r + 1'b1;
          end

          ptq_pkg::SM_DISP: begin
            push.vld = 1'b1;
            if (found_r) begin
              e.st            = ptq_pkg::EST_ACTIVE;
              we              = 1'b1;
              waddr           = bidx_r;
              wdata           = e;
              push.data.rkind = ptq_pkg::RK_GRANT;
              push.data.tag   = bword_r.tag;
              push.data.st    = ptq_pkg::ST_ACTIVE;
            end else begin
              push.data.st    = ptq_pkg::ST_NONE;
            end
            res_cnt_nxt = res_cnt_r + 1'b1;
            state_nxt   = ptq_pkg::S_FINISH;
          end

          ptq_pkg::SM_PEND: begin
            sidx_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = ptq_pkg::S_SCAN;
            if (found_r && room) begin
              push.vld          = 1'b1;
              push.data.rkind   = ptq_pkg::RK_NOTICE;
              push.data.tag     = bword_r.tag;
              push.data.st      = {1'b0, bword_r.st};
              res_cnt_nxt       = res_cnt_r + 1'b1;
              valid_nxt[bidx_r] = 1'b0;
              cnt_nxt           = cnt_r - 1'b1;
            end else begin
              mode_nxt = ptq_pkg::SM_MARK;
            end
          end

          ptq_pkg::SM_MARK: begin
            sidx_nxt  = '0;
            found_nxt = 1'b0;
            mode_nxt  = ptq_pkg::SM_FIN;
            state_nxt = ptq_pkg::S_SCAN;
          end

          ptq_pkg::SM_FIN: begin
            if (found_r && room) begin
              push.vld          = 1'b1;
              push.data.rkind   = ptq_pkg::RK_NOTICE;
              push.data.tag     = bword_r.tag;
              push.data.st      = {1'b0, bword_r.st};
              res_cnt_nxt       = res_cnt_r + 1'b1;
              valid_nxt[bidx_r] = 1'b0;
              sidx_nxt          = '0;
              found_nxt         = 1'b0;
              state_nxt         = ptq_pkg::S_SCAN;
            end else begin
              if (res_cnt_r == '0) begin
                push.vld     = 1'b1;
                push.data.st = ptq_pkg::ST_NONE;
                res_cnt_nxt  = res_cnt_r + 1'b1;
              end
              if (kind_r == ptq_pkg::KIND_PURGE) begin
                gen_nxt = ~gen_r;
              end
              state_nxt = ptq_pkg::S_FINISH;
            end
          end
        endcase
      end

      ptq_pkg::S_FINISH: begin
        drain.go    = 1'b1;
        drain.n     = res_cnt_r;
        drain.outst = ptq_pkg::OUT_CNT_W'(cnt_r);
        state_nxt   = ptq_pkg::S_WAIT;
      end

      ptq_pkg::S_WAIT: begin
        if (drain_done) begin
          state_nxt = ptq_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/ptq_outq.sv
`default_nettype none
module ptq_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ptq_pkg::push_t                push,
  input  wire ptq_pkg::drain_t               drain,
  output logic                               drain_done,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_result_kind,
  output logic [15:0]                        out_result_tag,
  output logic [2:0]                         out_task_status,
  output logic [ptq_pkg::OUT_CNT_W-1:0]      out_outstanding,
  output logic                               out_last
);

  ptq_pkg::drain_state_t state_r, state_nxt;

  logic [ptq_pkg::RES_CNT_W-1:0] n_r, n_nxt;
  logic [ptq_pkg::RES_CNT_W-1:0] k_r, k_nxt;
  logic [ptq_pkg::OUT_CNT_W-1:0] outst_r, outst_nxt;
  logic                          valid_r, valid_nxt;
  logic                          last_r, last_nxt;
  ptq_pkg::res_t                 res_r, res_nxt;
  logic [ptq_pkg::RES_W-1:0]     rdata;

  ptq_ram #(
    .WIDTH (ptq_pkg::RES_W),
    .DEPTH (ptq_pkg::MAX_RES)
  ) u_res_ram (
    .clk   (clk),
    .we    (push.vld),
    .waddr (push.idx),
    .wdata (push.data),
    .raddr (k_r[ptq_pkg::RES_IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptq_pkg::D_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    outst_r <= outst_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    outst_nxt  = outst_r;
    valid_nxt  = valid_r;
    last_nxt   = last_r;
    res_nxt    = res_r;
    drain_done = 1'b0;
    unique case (state_r)
      ptq_pkg::D_IDLE: begin
        if (drain.go) begin
          n_nxt     = drain.n;
          outst_nxt = drain.outst;
          k_nxt     = '0;
          state_nxt = ptq_pkg::D_REQ;
        end
      end
      ptq_pkg::D_REQ: begin
        state_nxt = ptq_pkg::D_LOAD;
      end
      ptq_pkg::D_LOAD: begin
        res_nxt   = ptq_pkg::res_t'(rdata);
        last_nxt  = (k_r == n_r - 1'b1);
        valid_nxt = 1'b1;
        state_nxt = ptq_pkg::D_HOLD;
      end
      ptq_pkg::D_HOLD: begin
        if (out_ready) begin
          valid_nxt = 1'b0;
          if (last_r) begin
            drain_done = 1'b1;
            state_nxt  = ptq_pkg::D_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ptq_pkg::D_REQ;
          end
        end
      end
    endcase
  end

  assign out_valid       = valid_r;
  assign out_result_kind = res_r.rkind;
  assign out_result_tag  = res_r.tag;
  assign out_task_status = res_r.st;
  assign out_outstanding = outst_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

### hdl/priority_task_queue_tracker_unit.sv
// Priority task queue tracker. Holds up to 16 tagged tasks in a synchronous
// entry memory (tag, priority, status, generation, order stamp) with valid
// bits in flops. One item is taken at a time: in_ready is high only while
// the block is idle. Each item of a known kind first walks the entry memory
// one entry per cycle: submit, wait, cancel, status and done use one lookup
// pass; dispatch uses one head-search pass; purge and reset run one pass per
// removal notice plus one pass for the generation marking and the closing
// searches, flush one pass per removal notice plus a closing search, up to
// 19 passes. Results of the item are collected in a 16-entry result memory
// and then delivered in order, each beat passing through a read request, a
// load and a hold state that waits on out_ready. The outstanding count on
// every beat is the count after the item. No clearing pass follows reset.
`default_nettype none
`include "priority_task_queue_tracker_unit_defines.svh"
module priority_task_queue_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_kind,
  input  wire logic [15:0] in_task_tag,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic        in_success,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [15:0]      out_result_tag,
  output logic [2:0]       out_task_status,
  output logic [4:0]       out_outstanding,
  output logic             out_last
);

  ptq_pkg::push_t  push;
  ptq_pkg::drain_t drain;
  logic            drain_done;

  // table walk and update sequencer
  ptq_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_task_tag     (in_task_tag),
    .in_priority_req (in_priority_req),
    .in_success      (in_success),
    .push            (push),
    .drain           (drain),
    .drain_done      (drain_done)
  );

  // result buffer; replay each beat with the final outstanding count
  ptq_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .drain           (drain),
    .drain_done      (drain_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_result_tag  (out_result_tag),
    .out_task_status (out_task_status),
    .out_outstanding (out_outstanding),
    .out_last        (out_last)
  );

  // no beat is shown while results of the item are still being collected
  `PTQ_ASSERT_NOW(a_push_quiet, clk, rst_n, push.vld, !out_valid)
  // an accepted item closes the input until its results are delivered
  `PTQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  // every item yields at least one result
  `PTQ_ASSERT_NOW(a_drain_nonempty, clk, rst_n, drain.go, drain.n != '0)
  // outstanding never exceeds the table size
  `PTQ_ASSERT_NOW(a_outst_range, clk, rst_n, out_valid, out_outstanding <= 5'd16)

endmodule
`default_nettype wire
